FILE: src/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: src/ffca_pkg.sv
// shared types and constants of the first-fit chunk allocator
package ffca_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AlignW = 5;
  localparam logic [DataW-1:0] PageSizeReset = 32'd268435456;
  localparam logic [AlignW-1:0] AlignLog2Reset = 5'd16;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef enum logic {
    REG_PAGE_SIZE  = 1'b0,
    REG_ALIGN_LOG2 = 1'b1
  } reg_idx_e;

  // command broadcast to every cell
  typedef struct packed {
    logic             exec;
    cmd_e             cmd;
    logic [DataW:0]   aligned;
    logic [DataW-1:0] size;
    logic [DataW-1:0] offs;
    logic [DataW:0]   blk_end;
    logic [DataW-1:0] page;
  } op_t;

  // priority chain between neighboring cells
  typedef struct packed {
    logic             hit;
    logic [DataW-1:0] grant;
  } chain_t;

endpackage

FILE: src/ffca_cell.sv
// one free-table entry with its compare, update and priority link
module ffca_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffca_pkg::op_t    op_i,
  input  logic            live_i,
  input  logic            append_i,
  input  ffca_pkg::chain_t chain_i,
  output ffca_pkg::chain_t chain_o
);
  import ffca_pkg::*;

  logic [DataW-1:0] start_q, start_d;
  logic [DataW-1:0] len_q, len_d;
  logic             alloc_hit, free_hit, match, take;
  logic [DataW:0]   merge_sum;

  assign alloc_hit = live_i && ({1'b0, len_q} > op_i.aligned);
  assign free_hit  = live_i && (op_i.blk_end == {1'b0, start_q});
  assign match     = ((op_i.cmd == CMD_ALLOC) && alloc_hit) ||
                     ((op_i.cmd == CMD_FREE) && free_hit);
  assign take      = op_i.exec && match && !chain_i.hit;
  assign merge_sum = {1'b0, len_q} + {1'b0, op_i.size};

  assign chain_o.hit   = chain_i.hit || match;
  assign chain_o.grant = (match && !chain_i.hit) ? start_q : chain_i.grant;

  always_comb begin
    start_d = start_q;
    len_d   = len_q;
    if (op_i.exec && (op_i.cmd == CMD_RESET)) begin
      if (FIRST) begin
        start_d = '0;
        len_d   = op_i.page;
      end
    end else if (take && (op_i.cmd == CMD_ALLOC)) begin
      start_d = start_q + op_i.aligned[DataW-1:0];
      len_d   = len_q - op_i.aligned[DataW-1:0];
    end else if (take) begin
      start_d = op_i.offs;
      len_d   = merge_sum[DataW] ? '1 : merge_sum[DataW-1:0];
    end else if (append_i) begin
      start_d = op_i.offs;
      len_d   = op_i.size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      len_q   <= FIRST ? PageSizeReset : '0;
    end else begin
      start_q <= start_d;
      len_q   <= len_d;
    end
  end

endmodule

FILE: src/first_fit_chunk_allocator.sv
// top level: command register, row of free-table cells, result register
//
// channel     | dir | tdata (low to high)              | tuser
// s_axis      | in  | size_bytes, block_offset         | command
// m_axis      | out | granted_offset, bytes_in_use     | status
// cfg         | in  | plain write: cfg_we_i, cfg_idx_i, cfg_data_i
//
// an item's command and its aligned size are registered in the command register; once the
// result register is free, all cells compare in parallel and update through the priority chain
// the input is taken again while a finished result waits on m_axis
// reset (rst_ni low) restores one free chunk of 256 MiB at offset 0 at once
// a stalled result holds the command register, which holds s_axis_tready low
module first_fit_chunk_allocator #(
  parameter int unsigned FREE_ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,  // size_bytes, block_offset
  input  logic [1:0]                  s_axis_tuser,  // command
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [63:0]                 m_axis_tdata,  // granted_offset, bytes_in_use
  output logic [1:0]                  m_axis_tuser,  // status
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [ffca_pkg::DataW-1:0]  cfg_data_i
);
  import ffca_pkg::*;

  localparam int unsigned CntW = $clog2(FREE_ENTRIES + 1);

  logic [DataW-1:0]  page_q;
  logic [AlignW-1:0] align_q;
  logic              cmd_v_q, out_v_q;
  op_t               op_q, op;
  logic [CntW-1:0]   count_q, count_d;
  logic [DataW-1:0]  used_q, used_d;
  logic [1:0]        status_q, status_d;
  logic [DataW-1:0]  grant_q, grant_d;
  logic              accept, exec, hit_end;
  logic [DataW:0]    unit_mask, aligned_in, used_sum;
  logic [DataW-1:0]  in_size, in_offs;
  chain_t            chain [FREE_ENTRIES+1];
  logic [FREE_ENTRIES-1:0] live, append;

  assign in_size = s_axis_tdata[31:0];
  assign in_offs = s_axis_tdata[63:32];

  assign s_axis_tready = !cmd_v_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign exec          = cmd_v_q && (!out_v_q || m_axis_tready);

  assign unit_mask  = (33'd1 << align_q) - 33'd1;
  assign aligned_in = ({1'b0, in_size} + unit_mask) & ~unit_mask;

  always_comb begin
    op      = op_q;
    op.exec = exec;
    op.page = page_q;
  end

  assign chain[0].hit   = 1'b0;
  assign chain[0].grant = '0;

  for (genvar i = 0; i < FREE_ENTRIES; i++) begin : g_cell
    assign live[i]   = CntW'(i) < count_q;
    assign append[i] = exec && (op_q.cmd == CMD_FREE) && !hit_end && (count_q == CntW'(i));
    ffca_cell #(
      .FIRST(i == 0)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .live_i  (live[i]),
      .append_i(append[i]),
      .chain_i (chain[i]),
      .chain_o (chain[i+1])
    );
  end

  assign hit_end  = chain[FREE_ENTRIES].hit;
  assign used_sum = {1'b0, used_q} + op_q.aligned;

  always_comb begin
    count_d  = count_q;
    used_d   = used_q;
    status_d = ST_OK;
    grant_d  = '0;
    case (op_q.cmd)
      CMD_ALLOC: begin
        if (hit_end) begin
          grant_d = chain[FREE_ENTRIES].grant;
          used_d  = used_sum[DataW] ? '1 : used_sum[DataW-1:0];
        end else begin
          status_d = ST_NOSPACE;
        end
      end
      CMD_FREE: begin
        if (!hit_end) begin
          if (count_q == CntW'(FREE_ENTRIES)) begin
            status_d = ST_FULL;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        used_d = (used_q > op_q.size) ? used_q - op_q.size : '0;
      end
      CMD_RESET: begin
        count_d = CntW'(1);
        used_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q   <= PageSizeReset;
      align_q  <= AlignLog2Reset;
      cmd_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
      count_q  <= CntW'(1);
      used_q   <= '0;
      op_q     <= '0;
      status_q <= ST_OK;
      grant_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_PAGE_SIZE:  page_q  <= cfg_data_i;
          REG_ALIGN_LOG2: align_q <= cfg_data_i[AlignW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        cmd_v_q         <= 1'b1;
        op_q.cmd        <= cmd_e'(s_axis_tuser);
        op_q.aligned    <= aligned_in;
        op_q.size       <= in_size;
        op_q.offs       <= in_offs;
        op_q.blk_end    <= {1'b0, in_offs} + {1'b0, in_size};
      end else if (exec) begin
        cmd_v_q <= 1'b0;
      end
      if (exec) begin
        out_v_q  <= 1'b1;
        count_q  <= count_d;
        used_q   <= used_d;
        status_q <= status_d;
        grant_q  <= grant_d;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {used_q, grant_q};
  assign m_axis_tuser  = status_q;

endmodule

FILE: src/ffca_checker.sv
// port-level checks of the allocator, bound to the top level
`include "assert_macros.svh"

module ffca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import ffca_pkg::*;

  // a stalled result keeps its payload
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // status has only three codes
  `ASSERT_IMPL(a_status_code, m_axis_tvalid, m_axis_tuser != ST_UNUSED)
  // a failed item grants nothing
  `ASSERT_IMPL(a_fail_zero, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata[31:0] == 32'd0)
  // after a transfer in, the input stays closed until the result is produced
  `ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind first_fit_chunk_allocator ffca_checker u_ffca_checker (.*);
